@@ hw/rtl/tar_pkg.sv @@
// Shared types, widths and constants for the tilt angle ring logger.
package tar_pkg;

  // Defaults for the top-level parameters
  localparam int RingDepthDef   = 64;
  localparam int CordicStepsDef = 16;

  // Field widths
  localparam int AxisW    = 16;
  localparam int TsW      = 32;
  localparam int AngleW   = 15;
  localparam int SlotOutW = 6;
  localparam int RecW     = TsW + AngleW;

  // Arithmetic widths
  localparam int SqW   = 32;          // x*x + y*y, at most 2^31
  localparam int RootW = 32;          // floor(sqrt(sq * 2^32)), Q16 magnitude
  localparam int CordW = 36;          // CORDIC X/Y, signed, with gain headroom
  localparam int TblW  = 22;          // atan step in Q16 degrees
  localparam int AccW  = 26;          // signed angle accumulator, Q16 degrees
  localparam int FracShift = 9;       // Q16 to Q7

  localparam logic signed [AccW-1:0] Deg90Q16  = 26'sd5898240;
  localparam logic signed [AccW-1:0] Deg180Q16 = 26'sd11796480;
  localparam logic [AccW-1:0]        RoundBias = 26'd256;

  // Write request into the ring store
  typedef struct packed {
    logic             en;
    logic [TsW-1:0]   ts;
    logic [AngleW-1:0] tilt;
  } ring_wr_t;

  // round(atan(2^-i) degrees * 2^16)
  function automatic logic [TblW-1:0] atan_step(input logic [4:0] idx);
    logic [TblW-1:0] val;
    unique case (idx)
      5'd0:    val = 22'd2949120;
      5'd1:    val = 22'd1740967;
      5'd2:    val = 22'd919879;
      5'd3:    val = 22'd466945;
      5'd4:    val = 22'd234379;
      5'd5:    val = 22'd117304;
      5'd6:    val = 22'd58666;
      5'd7:    val = 22'd29335;
      5'd8:    val = 22'd14668;
      5'd9:    val = 22'd7334;
      5'd10:   val = 22'd3667;
      5'd11:   val = 22'd1833;
      5'd12:   val = 22'd917;
      5'd13:   val = 22'd458;
      5'd14:   val = 22'd229;
      5'd15:   val = 22'd115;
      5'd16:   val = 22'd57;
      5'd17:   val = 22'd29;
      5'd18:   val = 22'd14;
      5'd19:   val = 22'd7;
      5'd20:   val = 22'd4;
      5'd21:   val = 22'd2;
      5'd22:   val = 22'd1;
      default: val = 22'd0;
    endcase
    return val;
  endfunction

endpackage

@@ hw/rtl/tar_sqrt.sv @@
// Digit-by-digit integer square root of (rad * 2^32), one result bit per cycle.
module tar_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tar_pkg::SqW-1:0]     rad_i,
  output logic                        done_o,
  output logic [tar_pkg::RootW-1:0]   root_o
);

  localparam int RootW = tar_pkg::RootW;
  localparam int RemW  = RootW + 2;
  localparam int CntW  = $clog2(RootW);

  logic                 busy_q, done_q;
  logic [CntW-1:0]      cnt_q;
  logic [tar_pkg::SqW-1:0] rad_q, rad_d;
  logic [RemW-1:0]      rem_q, rem_d;
  logic [RootW-1:0]     res_q, res_d;
  logic [RemW+1:0]      rem_sh;
  logic [RemW+1:0]      trial;

  // One restoring step: bring down two radicand bits, try (res<<2)|1
  always_comb begin
    rem_sh = {rem_q, rad_q[tar_pkg::SqW-1 -: 2]};
    trial  = {2'b00, res_q, 2'b01};
    rad_d  = {rad_q[tar_pkg::SqW-3:0], 2'b00};
    if (rem_sh >= trial) begin
      rem_d = RemW'(rem_sh - trial);
      res_d = {res_q[RootW-2:0], 1'b1};
    end else begin
      rem_d = rem_sh[RemW-1:0];
      res_d = {res_q[RootW-2:0], 1'b0};
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(RootW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q <= rad_i;
      rem_q <= '0;
      res_q <= '0;
    end else if (busy_q) begin
      rad_q <= rad_d;
      rem_q <= rem_d;
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q;

endmodule

@@ hw/rtl/tar_cordic.sv @@
// Vectoring CORDIC: angle of (Z, r) in Q16 degrees, one iteration per cycle.
module tar_cordic #(
  parameter int CORDIC_STEPS = tar_pkg::CordicStepsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [tar_pkg::RootW-1:0]         mag_i,
  input  logic signed [tar_pkg::AxisW-1:0]  axis_z_i,
  output logic                              done_o,
  output logic signed [tar_pkg::AccW-1:0]   acc_o
);

  localparam int CordW = tar_pkg::CordW;
  localparam int AccW  = tar_pkg::AccW;
  localparam int IdxW  = $clog2(CORDIC_STEPS);

  logic                    busy_q, done_q;
  logic [IdxW-1:0]         idx_q;
  logic signed [CordW-1:0] cx_q, cy_q, cx_d, cy_d;
  logic signed [AccW-1:0]  acc_q, acc_d;
  logic signed [CordW-1:0] dx, dy;
  logic signed [AccW-1:0]  step_ang;
  logic signed [CordW-1:0] z_ext, mag_ext;

  // Start vector; negative z is pre-rotated by 90 degrees
  assign z_ext   = {{(CordW - tar_pkg::AxisW - 16){axis_z_i[tar_pkg::AxisW-1]}},
                    axis_z_i, 16'h0000};
  assign mag_ext = {{(CordW - tar_pkg::RootW){1'b0}}, mag_i};

  // One micro-rotation driven by the sign of Y
  always_comb begin
    dx       = cy_q >>> idx_q;
    dy       = cx_q >>> idx_q;
    step_ang = {{(AccW - tar_pkg::TblW){1'b0}}, tar_pkg::atan_step(5'(idx_q))};
    if (!cy_q[CordW-1]) begin
      cx_d  = cx_q + dx;
      cy_d  = cy_q - dy;
      acc_d = acc_q + step_ang;
    end else begin
      cx_d  = cx_q - dx;
      cy_d  = cy_q + dy;
      acc_d = acc_q - step_ang;
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (busy_q) begin
        idx_q <= idx_q + IdxW'(1);
        if (idx_q == IdxW'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (!axis_z_i[tar_pkg::AxisW-1]) begin
        cx_q  <= z_ext;
        cy_q  <= mag_ext;
        acc_q <= '0;
      end else begin
        cx_q  <= mag_ext;
        cy_q  <= -z_ext;
        acc_q <= tar_pkg::Deg90Q16;
      end
    end else if (busy_q) begin
      cx_q  <= cx_d;
      cy_q  <= cy_d;
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

@@ hw/rtl/tar_ring.sv @@
// Ring store of timestamp and angle records with its write slot pointer.
module tar_ring #(
  parameter int RING_DEPTH = tar_pkg::RingDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tar_pkg::ring_wr_t           wr_i,
  output logic [$clog2(RING_DEPTH)-1:0] slot_o
);

  localparam int SlotW = $clog2(RING_DEPTH);

  logic [tar_pkg::RecW-1:0] mem_q [RING_DEPTH];
  logic [SlotW-1:0]         slot_q;

  // Record write: timestamp above, angle below
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[slot_q] <= {wr_i.ts, wr_i.tilt};
    end
  end

  // Slot pointer wraps at the depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (wr_i.en) begin
      if (slot_q == SlotW'(RING_DEPTH - 1)) begin
        slot_q <= '0;
      end else begin
        slot_q <= slot_q + SlotW'(1);
      end
    end
  end

  assign slot_o = slot_q;

endmodule

@@ hw/rtl/tilt_angle_ring_logger_core.sv @@
// Channel  Dir  Handshake             Payload
// in       in   in_valid_i/in_stall_o  accel_x_i, accel_y_i, accel_z_i, sample_time_i
// out      out  out_valid_o/out_stall_i tilt_degrees_o, slot_written_o
//
// One sample at a time: the input stays stalled from the input beat until the
// result is registered, and the next beat can be taken once it is; an all-zero
// sample skips the CORDIC. The time taken is set by the bit-serial square root
// and the CORDIC iterations (one per cycle), plus the squaring steps.
// Reset clears the control, the output valid and the write slot; the ring
// store itself holds no reset value. A stalled output only holds the block
// if a second result is ready before the first beat has been taken.
module tilt_angle_ring_logger_core #(
  parameter int RING_DEPTH   = tar_pkg::RingDepthDef,
  parameter int CORDIC_STEPS = tar_pkg::CordicStepsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [tar_pkg::AxisW-1:0]   accel_x_i,
  input  logic signed [tar_pkg::AxisW-1:0]   accel_y_i,
  input  logic signed [tar_pkg::AxisW-1:0]   accel_z_i,
  input  logic [tar_pkg::TsW-1:0]            sample_time_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [tar_pkg::AngleW-1:0]         tilt_degrees_o,
  output logic [tar_pkg::SlotOutW-1:0]       slot_written_o
);

  localparam int SlotW    = $clog2(RING_DEPTH);
  localparam int SlotExtW = (SlotW > tar_pkg::SlotOutW) ? SlotW : tar_pkg::SlotOutW;
  localparam int AccW     = tar_pkg::AccW;

  typedef enum logic [2:0] {
    StIdle,
    StSqX,
    StSqY,
    StRoot,
    StRot,
    StFin
  } state_e;

  state_e state_q, state_d;

  logic signed [tar_pkg::AxisW-1:0] x_q, y_q, z_q;
  logic [tar_pkg::TsW-1:0]          ts_q;
  logic                             zero_q;
  logic [tar_pkg::SqW-1:0]          sq_q, sq_sum;
  logic signed [tar_pkg::AxisW-1:0] mul_a;
  logic signed [2*tar_pkg::AxisW-1:0] prod;

  logic                             in_acc;
  logic                             root_start, root_done;
  logic [tar_pkg::RootW-1:0]        root;
  logic                             rot_start, rot_done;
  logic signed [AccW-1:0]           rot_acc;

  logic signed [AccW-1:0]           acc_clip;
  logic [AccW-1:0]                  turn, round_sum;
  logic [tar_pkg::AngleW-1:0]       tilt_d;
  logic                             put_ok;

  tar_pkg::ring_wr_t                ring_wr;
  logic [SlotW-1:0]                 slot;
  logic [SlotExtW-1:0]              slot_ext;

  logic                             out_valid_q;
  logic [tar_pkg::AngleW-1:0]       tilt_q;
  logic [tar_pkg::SlotOutW-1:0]     slot_out_q;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;

  // Shared squarer: x*x first, then accumulate y*y
  assign mul_a  = (state_q == StSqX) ? x_q : y_q;
  assign prod   = mul_a * mul_a;
  assign sq_sum = sq_q + unsigned'(prod);

  // Sample capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q    <= accel_x_i;
      y_q    <= accel_y_i;
      z_q    <= accel_z_i;
      ts_q   <= sample_time_i;
      zero_q <= (accel_x_i == '0) && (accel_y_i == '0) && (accel_z_i == '0);
    end
    if (state_q == StSqX) begin
      sq_q <= unsigned'(prod);
    end
  end

  assign root_start = (state_q == StSqY);
  assign rot_start  = (state_q == StRoot) && root_done && !zero_q;

  tar_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .rad_i   (sq_sum),
    .done_o  (root_done),
    .root_o  (root)
  );

  tar_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (rot_start),
    .mag_i    (root),
    .axis_z_i (z_q),
    .done_o   (rot_done),
    .acc_o    (rot_acc)
  );

  // Clamp to [0, 180] deg, flip, round half up to Q7; all-zero sample reads 180 deg
  always_comb begin
    if (zero_q || rot_acc[AccW-1]) begin
      acc_clip = '0;
    end else if (rot_acc > tar_pkg::Deg180Q16) begin
      acc_clip = tar_pkg::Deg180Q16;
    end else begin
      acc_clip = rot_acc;
    end
    turn      = unsigned'(tar_pkg::Deg180Q16 - acc_clip);
    round_sum = turn + tar_pkg::RoundBias;
    tilt_d    = round_sum[tar_pkg::FracShift +: tar_pkg::AngleW];
  end

  assign put_ok = (state_q == StFin) && (!out_valid_q || !out_stall_i);

  // Record into the ring as the result goes to the output register
  assign ring_wr.en   = put_ok;
  assign ring_wr.ts   = ts_q;
  assign ring_wr.tilt = tilt_d;

  tar_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (ring_wr),
    .slot_o (slot)
  );

  assign slot_ext = SlotExtW'(slot);

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_acc) state_d = StSqX;
      StSqX:   state_d = StSqY;
      StSqY:   state_d = StRoot;
      StRoot:  if (root_done) state_d = zero_q ? StFin : StRot;
      StRot:   if (rot_done) state_d = StFin;
      StFin:   if (put_ok) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // State and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (put_ok) begin
        out_valid_q <= 1'b1;
        tilt_q      <= tilt_d;
        slot_out_q  <= slot_ext[tar_pkg::SlotOutW-1:0];
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign tilt_degrees_o = tilt_q;
  assign slot_written_o = slot_out_q;

endmodule

@@ bench/tilt_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the tilt logger, predicts each result from the
// input beat and checks the output beats against the oldest prediction.
module tilt_checker #(
  parameter int RingDepth   = tar_pkg::RingDepthDef,
  parameter int CordicSteps = tar_pkg::CordicStepsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic signed [tar_pkg::AxisW-1:0]   accel_x_i,
  input  logic signed [tar_pkg::AxisW-1:0]   accel_y_i,
  input  logic signed [tar_pkg::AxisW-1:0]   accel_z_i,
  input  logic [tar_pkg::TsW-1:0]            sample_time_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic [tar_pkg::AngleW-1:0]         tilt_degrees_i,
  input  logic [tar_pkg::SlotOutW-1:0]       slot_written_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);

  localparam int     AtanLen  = 24;
  localparam longint Deg90Q16  = 64'sd5898240;
  localparam longint Deg180Q16 = 64'sd11796480;

  // atan(2^-i) in Q16 degrees, entry 0 on the right
  localparam logic [AtanLen-1:0][21:0] AtanQ16 = {
    22'd0, 22'd1, 22'd2, 22'd4, 22'd7, 22'd14, 22'd29, 22'd57,
    22'd115, 22'd229, 22'd458, 22'd917, 22'd1833, 22'd3667, 22'd7334, 22'd14668,
    22'd29335, 22'd58666, 22'd117304, 22'd234379, 22'd466945, 22'd919879,
    22'd1740967, 22'd2949120
  };

  typedef struct packed {
    logic [tar_pkg::AngleW-1:0]   tilt;
    logic [tar_pkg::SlotOutW-1:0] slot;
  } logged_angle_t;

  logged_angle_t angle_q[$];
  int unsigned   next_slot;

  // 180 - atan2(|xy|, z) in Q7 degrees, via Q16 magnitude and vectoring CORDIC
  function automatic logic [tar_pkg::AngleW-1:0] tilt_q7(
    input logic signed [tar_pkg::AxisW-1:0] ax,
    input logic signed [tar_pkg::AxisW-1:0] ay,
    input logic signed [tar_pkg::AxisW-1:0] az
  );
    longint      sq, mag, zq, cx, cy, acc, dx, dy, tilt;
    logic [63:0] rem, root, probe;
    sq    = longint'(ax) * longint'(ax) + longint'(ay) * longint'(ay);
    rem   = 64'(sq) << 32;
    root  = '0;
    probe = 64'h4000_0000_0000_0000;
    // bit-by-bit integer square root
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    mag = longint'(root);
    zq  = longint'(az) * 65536;
    if (ax == 0 && ay == 0 && az == 0) begin
      acc = 0;
    end else begin
      // negative z starts from a 90 degree pre-rotation
      if (az >= 0) begin
        cx = zq; cy = mag; acc = 0;
      end else begin
        cx = mag; cy = -zq; acc = Deg90Q16;
      end
      for (int i = 0; i < CordicSteps && i < AtanLen; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx = cx + dx; cy = cy - dy; acc = acc + longint'(AtanQ16[i]);
        end else begin
          cx = cx - dx; cy = cy + dy; acc = acc - longint'(AtanQ16[i]);
        end
      end
      if (acc < 0) acc = 0;
      if (acc > Deg180Q16) acc = Deg180Q16;
    end
    tilt = Deg180Q16 - acc;
    return tar_pkg::AngleW'((tilt + 256) >> 9);
  endfunction

  // predict on every input beat, compare on every output beat
  always @(posedge clk_i or negedge rst_ni) begin
    logged_angle_t want;
    if (!rst_ni) begin
      angle_q.delete();
      next_slot    = 0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        want.tilt = tilt_q7(accel_x_i, accel_y_i, accel_z_i);
        want.slot = next_slot[tar_pkg::SlotOutW-1:0];
        angle_q.push_back(want);
        next_slot = (next_slot + 1) % RingDepth;
      end
      if (out_valid_i && !out_stall_i) begin
        if (angle_q.size() == 0) begin
          $error("unexpected result beat: tilt_degrees %0d slot_written %0d",
                 tilt_degrees_i, slot_written_i);
          fail_count_o++;
        end else begin
          want = angle_q.pop_front();
          if (tilt_degrees_i !== want.tilt) begin
            $error("tilt_degrees mismatch: expected %0d, actual %0d",
                   want.tilt, tilt_degrees_i);
            fail_count_o++;
          end
          if (slot_written_i !== want.slot) begin
            $error("slot_written mismatch: expected %0d, actual %0d",
                   want.slot, slot_written_i);
            fail_count_o++;
          end
        end
      end
      pending_o = angle_q.size();
    end
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int RandomSamples = 1030;
  localparam int QuietFrom     = 900;
  localparam int HoldOffCycles = 600;
  localparam int CycleLimit    = 1000000;

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  logic signed [tar_pkg::AxisW-1:0] accel_x;
  logic signed [tar_pkg::AxisW-1:0] accel_y;
  logic signed [tar_pkg::AxisW-1:0] accel_z;
  logic [tar_pkg::TsW-1:0]          sample_time;
  logic                             out_valid;
  logic                             out_stall;
  logic [tar_pkg::AngleW-1:0]       tilt_degrees;
  logic [tar_pkg::SlotOutW-1:0]     slot_written;
  int                               fail_count;
  int                               pending;
  int unsigned                      samples_taken;
  bit                               quiet;
  bit                               hold_off_done;

  tilt_angle_ring_logger_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .accel_x_i      (accel_x),
    .accel_y_i      (accel_y),
    .accel_z_i      (accel_z),
    .sample_time_i  (sample_time),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .tilt_degrees_o (tilt_degrees),
    .slot_written_o (slot_written)
  );

  tilt_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .accel_x_i      (accel_x),
    .accel_y_i      (accel_y),
    .accel_z_i      (accel_z),
    .sample_time_i  (sample_time),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .tilt_degrees_i (tilt_degrees),
    .slot_written_i (slot_written),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one sample beat, with an occasional idle gap first
  task automatic send_sample(input logic signed [tar_pkg::AxisW-1:0] x,
                             input logic signed [tar_pkg::AxisW-1:0] y,
                             input logic signed [tar_pkg::AxisW-1:0] z,
                             input logic [tar_pkg::TsW-1:0] stamp);
    int bursts;
    if (!quiet && $urandom_range(0, 2) == 0) begin
      // a run of bursts now and then, so gaps reach past the busy window
      bursts = ($urandom_range(0, 5) == 0) ? $urandom_range(2, 12) : 1;
      in_valid <= 1'b0;
      for (int b = 0; b < bursts; b++) begin
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    in_valid    <= 1'b1;
    accel_x     <= x;
    accel_y     <= y;
    accel_z     <= z;
    sample_time <= stamp;
    do @(posedge clk); while (in_stall);
    samples_taken++;
    @(negedge clk);
  endtask

  function automatic logic signed [tar_pkg::AxisW-1:0] corner_count();
    case ($urandom_range(0, 4))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return -16'sd1;
      3:       return 16'sd1;
      default: return 16'sd0;
    endcase
  endfunction

  function automatic logic signed [tar_pkg::AxisW-1:0] small_count();
    return tar_pkg::AxisW'(int'($urandom_range(0, 8)) - 4);
  endfunction

  // random sample drawn from one of several shapes
  task automatic send_random_sample();
    logic signed [tar_pkg::AxisW-1:0] x, y, z;
    case ($urandom_range(0, 5))
      0, 1: begin
        x = tar_pkg::AxisW'($urandom);
        y = tar_pkg::AxisW'($urandom);
        z = tar_pkg::AxisW'($urandom);
      end
      2: begin
        x = small_count();
        y = small_count();
        z = small_count();
      end
      3: begin
        // one axis carries gravity, the others are near zero
        x = small_count();
        y = small_count();
        z = tar_pkg::AxisW'($urandom);
        if ($urandom_range(0, 1)) begin
          x = z;
          z = small_count();
        end
      end
      4: begin
        x = tar_pkg::AxisW'(int'($urandom_range(0, 40000)) - 20000);
        y = tar_pkg::AxisW'(int'($urandom_range(0, 40000)) - 20000);
        z = tar_pkg::AxisW'(int'($urandom_range(0, 40000)) - 20000);
      end
      default: begin
        x = corner_count();
        y = corner_count();
        z = corner_count();
      end
    endcase
    send_sample(x, y, z, $urandom);
  endtask

  // receiver: random stall bursts, one long hold-off, none at the end
  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(negedge clk);
      end else if (!hold_off_done && samples_taken >= 60) begin
        // hold the output long enough for the block to back up its input
        hold_off_done = 1'b1;
        out_stall <= 1'b1;
        for (int c = 0; c < HoldOffCycles; c++) @(negedge clk);
      end else if ($urandom_range(0, 1)) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 24)) @(negedge clk);
      end
    end
  end

  // watchdog
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // stimulus and verdict
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    accel_x       = '0;
    accel_y       = '0;
    accel_z       = '0;
    sample_time   = '0;
    samples_taken = 0;
    quiet         = 1'b0;
    hold_off_done = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // all axes zero reads as 180 degrees
    send_sample(16'sd0, 16'sd0, 16'sd0, 32'h0000_0000);
    send_sample(16'sd0, 16'sd0, 16'sd0, 32'hFFFF_FFFF);
    // straight along z, both signs: angle lands on the clamp limits
    send_sample(16'sd0, 16'sd0, 16'sh7FFF, 32'hAAAA_AAAA);
    send_sample(16'sd0, 16'sd0, 16'sh8000, 32'h5555_5555);
    send_sample(16'sd0, 16'sd0, 16'sd1, 32'h0000_0001);
    send_sample(16'sd0, 16'sd0, -16'sd1, 32'h8000_0000);
    // horizontal: 90 degrees
    send_sample(16'sh7FFF, 16'sd0, 16'sd0, 32'h7FFF_FFFF);
    send_sample(16'sd0, 16'sh8000, 16'sd0, 32'h1234_5678);
    send_sample(16'sd1, 16'sd0, 16'sd0, 32'hFEDC_BA98);
    send_sample(-16'sd1, 16'sd0, 16'sd0, 32'h0F0F_0F0F);
    // full-scale corners, largest magnitude
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 32'hF0F0_F0F0);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'h0000_FFFF);
    send_sample(16'sh8000, 16'sh8000, 16'sh7FFF, 32'hFFFF_0000);
    send_sample(16'sh7FFF, 16'sh8000, 16'sh8000, 32'hDEAD_BEEF);
    // tiny magnitudes near the axes, overshoot of the residue
    send_sample(16'sd1, 16'sd1, -16'sd1, 32'h0000_0002);
    send_sample(16'sd1, -16'sd1, 16'sd1, 32'h0000_0003);
    send_sample(-16'sd1, 16'sd0, 16'sh8000, 32'h0000_0004);
    send_sample(16'sd1, 16'sd0, 16'sh7FFF, 32'h0000_0005);
    send_sample(16'sh7FFF, 16'sd0, -16'sd1, 32'h0000_0006);
    send_sample(16'sh8000, 16'sd0, 16'sd1, 32'h0000_0007);
    // resting flat at 1 g
    send_sample(16'sd0, 16'sd0, 16'sd16384, 32'h0000_03E8);
    send_sample(16'sd0, 16'sd0, -16'sd16384, 32'h0000_07D0);

    for (int n = 0; n < RandomSamples; n++) begin
      if (n == QuietFrom) quiet = 1'b1;
      send_random_sample();
    end
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
